>>> rtl/calendar_field_editor_macros.svh
// Assertion macros used by the calendar field editor RTL.
`ifndef CALENDAR_FIELD_EDITOR_MACROS_SVH
`define CALENDAR_FIELD_EDITOR_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define CFE_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Antecedent at one edge implies the consequent at the next edge.
`define CFE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/cfe_pkg.sv
// Types, codes and month length lookup for the calendar field editor.
package cfe_pkg;

	typedef enum logic [1:0] {
		OP_LOAD = 2'd0,
		OP_INC  = 2'd1,
		OP_DEC  = 2'd2
	} cfe_op_t;

	typedef enum logic [2:0] {
		SEL_YEAR   = 3'd0,
		SEL_MONTH  = 3'd1,
		SEL_DAY    = 3'd2,
		SEL_HOUR   = 3'd3,
		SEL_MINUTE = 3'd4
	} cfe_sel_t;

	localparam logic [6:0] YEAR_MAX   = 7'd99;
	localparam logic [3:0] MONTH_MAX  = 4'd11;
	localparam logic [4:0] HOUR_MAX   = 5'd23;
	localparam logic [5:0] MINUTE_MAX = 6'd59;
	localparam logic [3:0] MONTH_FEB  = 4'd1;

	typedef struct packed {
		logic [1:0] operation;
		logic [2:0] field_select;
		logic [6:0] load_year;
		logic [3:0] load_month;
		logic [4:0] load_day;
		logic [4:0] load_hour;
		logic [5:0] load_minute;
	} cfe_in_t;

	typedef struct packed {
		logic [6:0] year_now;
		logic [3:0] month_now;
		logic [4:0] day_now;
		logic [4:0] hour_now;
		logic [5:0] minute_now;
		logic [4:0] days_in_month;
	} cfe_out_t;

	// Held calendar state.
	typedef struct packed {
		logic [6:0] year;
		logic [3:0] month;
		logic [4:0] day;
		logic [4:0] hour;
		logic [5:0] minute;
	} cfe_time_t;

	// Days in a zero-based month; codes above December read as December.
	function automatic logic [4:0] month_len(input logic [3:0] month, input logic [6:0] year);
		logic [4:0] len;
		len = 5'd31;
		case (month) inside
			MONTH_FEB:                    len = (year[1:0] == 2'b00) ? 5'd29 : 5'd28;
			4'd3, 4'd5, 4'd8, 4'd10:      len = 5'd30;
			default:                      len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

>>> rtl/cfe_if.sv
// Valid/ready channel interfaces for the calendar field editor items.
interface cfe_cmd_if;
	logic           valid;
	logic           ready;
	cfe_pkg::cfe_in_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface cfe_rsp_if;
	logic            valid;
	logic            ready;
	cfe_pkg::cfe_out_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/calendar_field_editor.sv
// Calendar field editor top level: date/time state with load and per-field step items.
// Holds a date and time (year 2000-2099 as an offset, zero-based month and day,
// hour, minute). Each item on cmd either loads all five fields, saturating each
// to its range and clamping the day to the loaded month, or steps one field up
// or down with wraparound; year and month steps clamp the day to the new month
// length, day steps wrap within the month, and February has 29 days in years
// divisible by four. Unused operation or field codes leave the state alone.
// Every item yields exactly one item on rsp with the updated fields and the
// current month length. Throughput is one item per clock while rsp is not
// stalled: an item is taken into the input stage, then a single combinational
// pass computes the new state, which is written to the state registers and
// the result register together once the result register is empty or being
// drained. The result register lets the input stage keep accepting while a
// result waits; cmd.ready drops only when both are full and rsp is stalled.
`include "calendar_field_editor_macros.svh"

module calendar_field_editor (
	input  logic      clk,
	input  logic      arst_n,
	cfe_cmd_if.sink   cmd,
	cfe_rsp_if.source rsp
);
	import cfe_pkg::*;

	logic       valid_s1;
	cfe_in_t    item_s1;
	cfe_time_t  cal_q;
	cfe_time_t  cal_nxt;
	logic [4:0] dim_nxt;
	logic       rsp_valid_q;
	cfe_out_t   rsp_data_q;
	logic       advance;
	logic       state_ok;
	logic       rsp_mirrors;

	// Input stage moves on when the result register is empty or being drained.
	assign advance   = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign cmd.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			item_s1 <= cmd.data;
		end
	end

	cfe_step u_step (
		.cur           (cal_q),
		.item          (item_s1),
		.nxt           (cal_nxt),
		.days_in_month (dim_nxt)
	);

	// Calendar state, updated in the same edge that loads the result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= '0;
		end else if (advance) begin
			cal_q <= cal_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_data_q.year_now      <= cal_nxt.year;
			rsp_data_q.month_now     <= cal_nxt.month;
			rsp_data_q.day_now       <= cal_nxt.day;
			rsp_data_q.hour_now      <= cal_nxt.hour;
			rsp_data_q.minute_now    <= cal_nxt.minute;
			rsp_data_q.days_in_month <= dim_nxt;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

	// Held state never leaves its ranges, and the day fits the held month.
	assign state_ok = (cal_q.year <= YEAR_MAX) && (cal_q.month <= MONTH_MAX)
		&& (cal_q.hour <= HOUR_MAX) && (cal_q.minute <= MINUTE_MAX)
		&& (cal_q.day < month_len(cal_q.month, cal_q.year));
	// A pending result always mirrors the held state.
	assign rsp_mirrors = (rsp_data_q.year_now == cal_q.year)
		&& (rsp_data_q.month_now == cal_q.month) && (rsp_data_q.day_now == cal_q.day)
		&& (rsp_data_q.hour_now == cal_q.hour) && (rsp_data_q.minute_now == cal_q.minute);

	`CFE_ASSERT_ALWAYS(a_fields_in_range, state_ok, "calendar state out of range")
	`CFE_ASSERT_ALWAYS(a_rsp_matches_state, !rsp_valid_q || rsp_mirrors, "result differs from held state")
	// A stalled input stage keeps its item.
	`CFE_ASSERT_NEXT(a_s1_held, valid_s1 && !advance, valid_s1, "input stage item lost while stalled")
	// State only changes when an item leaves the input stage.
	`CFE_ASSERT_NEXT(a_state_quiet, !advance, $stable(cal_q), "state changed without an item")

endmodule

>>> rtl/cfe_step.sv
// Next calendar state for one item: load with saturation, field steps, day clamp.
module cfe_step (
	input  cfe_pkg::cfe_time_t cur,
	input  cfe_pkg::cfe_in_t   item,
	output cfe_pkg::cfe_time_t nxt,
	output logic [4:0]         days_in_month
);
	import cfe_pkg::*;

	cfe_time_t  cand;
	logic       day_up;
	logic [4:0] len_cur;
	logic [4:0] len_nxt;

	assign len_cur = month_len(cur.month, cur.year);
	assign len_nxt = month_len(cand.month, cand.year);

	always_comb begin
		cand   = cur;
		day_up = 1'b0;
		unique case (item.operation)
			OP_LOAD: begin
				cand.year   = (item.load_year > YEAR_MAX) ? YEAR_MAX : item.load_year;
				cand.month  = (item.load_month > MONTH_MAX) ? MONTH_MAX : item.load_month;
				cand.day    = item.load_day;
				cand.hour   = (item.load_hour > HOUR_MAX) ? HOUR_MAX : item.load_hour;
				cand.minute = (item.load_minute > MINUTE_MAX) ? MINUTE_MAX : item.load_minute;
			end
			OP_INC: begin
				unique case (item.field_select)
					SEL_YEAR:   cand.year = (cur.year >= YEAR_MAX) ? 7'd0 : cur.year + 7'd1;
					SEL_MONTH:  cand.month = (cur.month >= MONTH_MAX) ? 4'd0 : cur.month + 4'd1;
					SEL_DAY: begin
						cand.day = cur.day + 5'd1;
						day_up   = 1'b1;
					end
					SEL_HOUR:   cand.hour = (cur.hour >= HOUR_MAX) ? 5'd0 : cur.hour + 5'd1;
					SEL_MINUTE: cand.minute = (cur.minute >= MINUTE_MAX) ? 6'd0
						: cur.minute + 6'd1;
					default: ;
				endcase
			end
			OP_DEC: begin
				unique case (item.field_select)
					SEL_YEAR:   cand.year = (cur.year == 7'd0) ? YEAR_MAX : cur.year - 7'd1;
					SEL_MONTH:  cand.month = (cur.month == 4'd0) ? MONTH_MAX : cur.month - 4'd1;
					SEL_DAY:    cand.day = (cur.day == 5'd0) ? len_cur - 5'd1 : cur.day - 5'd1;
					SEL_HOUR:   cand.hour = (cur.hour == 5'd0) ? HOUR_MAX : cur.hour - 5'd1;
					SEL_MINUTE: cand.minute = (cur.minute == 6'd0) ? MINUTE_MAX
						: cur.minute - 6'd1;
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	// Day step past month end wraps to the first; anything else beyond the end clamps.
	always_comb begin
		nxt = cand;
		if (cand.day >= len_nxt) begin
			nxt.day = day_up ? 5'd0 : len_nxt - 5'd1;
		end
	end

	assign days_in_month = len_nxt;

endmodule
